### design/csr_sparse_matvec_top_macros.svh
// Assertion helpers shared by the sparse matrix block.
`ifndef CSR_SPARSE_MATVEC_TOP_MACROS_SVH
`define CSR_SPARSE_MATVEC_TOP_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define CSM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define CSM_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/csm_pkg.sv
package csm_pkg;

    localparam int COL_W     = 7;
    localparam int ROW_W     = 7;
    localparam int VAL_W     = 32;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_OUT_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_VEC = 2'd1,
        OP_MUL = 2'd2,
        OP_CLR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK   = 2'd0,
        STS_OOB  = 2'd1,
        STS_FULL = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_OFF_HI,
        S_OFF_END,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_INS_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE,
        S_INC_RD,
        S_INC_WR,
        S_PR_RD,
        S_PR_ENT,
        S_PR_VEC,
        S_PR_ACC,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    load;
        logic    off_rd_lo;
        logic    off_rd_hi;
        logic    cap_begin;
        logic    cap_end;
        logic    pos_inc;
        logic    merge_wr;
        logic    shift_init;
        logic    shift_rd;
        logic    shift_wr;
        logic    place_wr;
        logic    inc_wr;
        logic    pr_ent_rd;
        logic    pr_vec_rd;
        logic    pr_mul;
        logic    pr_acc;
        logic    vec_wr;
        logic    clr;
        logic    set_status;
        status_t status_code;
        logic    respond;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic row_ok;
        logic col_ok;
        logic pos_lt_end;
        logic col_lt;
        logic col_eq;
        logic full;
        logic k_gt_pos;
        logic i_le_max;
        logic k_lt_end;
    } stat_t;

endpackage

### design/csm_ram.sv
module csm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

### design/csm_ctrl.sv
module csm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  csm_pkg::stat_t stat,
    output csm_pkg::cmd_t  cmd
);

    csm_pkg::state_t state_reg;
    csm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            csm_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = csm_pkg::S_DECODE;
                end
            end
            csm_pkg::S_DECODE:
            begin
                case (stat.op)
                    csm_pkg::OP_ADD:
                    begin
                        state_next = (stat.row_ok && stat.col_ok) ? csm_pkg::S_OFF_HI
                                                                  : csm_pkg::S_DONE;
                    end
                    csm_pkg::OP_MUL:
                    begin
                        state_next = stat.row_ok ? csm_pkg::S_OFF_HI : csm_pkg::S_DONE;
                    end
                    default:
                    begin
                        state_next = csm_pkg::S_DONE;
                    end
                endcase
            end
            csm_pkg::S_OFF_HI:   state_next = csm_pkg::S_OFF_END;
            csm_pkg::S_OFF_END:
            begin
                state_next = (stat.op == csm_pkg::OP_ADD) ? csm_pkg::S_SRCH_RD
                                                          : csm_pkg::S_PR_RD;
            end
            csm_pkg::S_SRCH_RD:
            begin
                state_next = stat.pos_lt_end ? csm_pkg::S_SRCH_CMP : csm_pkg::S_INS_CHK;
            end
            csm_pkg::S_SRCH_CMP:
            begin
                if (stat.col_lt)
                begin
                    state_next = csm_pkg::S_SRCH_RD;
                end
                else if (stat.col_eq)
                begin
                    state_next = csm_pkg::S_DONE;
                end
                else
                begin
                    state_next = csm_pkg::S_INS_CHK;
                end
            end
            csm_pkg::S_INS_CHK:
            begin
                state_next = stat.full ? csm_pkg::S_DONE : csm_pkg::S_SHIFT_RD;
            end
            csm_pkg::S_SHIFT_RD:
            begin
                state_next = stat.k_gt_pos ? csm_pkg::S_SHIFT_WR : csm_pkg::S_PLACE;
            end
            csm_pkg::S_SHIFT_WR: state_next = csm_pkg::S_SHIFT_RD;
            csm_pkg::S_PLACE:    state_next = csm_pkg::S_INC_RD;
            csm_pkg::S_INC_RD:
            begin
                state_next = stat.i_le_max ? csm_pkg::S_INC_WR : csm_pkg::S_DONE;
            end
            csm_pkg::S_INC_WR:   state_next = csm_pkg::S_INC_RD;
            csm_pkg::S_PR_RD:
            begin
                state_next = stat.k_lt_end ? csm_pkg::S_PR_ENT : csm_pkg::S_DONE;
            end
            csm_pkg::S_PR_ENT:   state_next = csm_pkg::S_PR_VEC;
            csm_pkg::S_PR_VEC:   state_next = csm_pkg::S_PR_ACC;
            csm_pkg::S_PR_ACC:   state_next = csm_pkg::S_PR_RD;
            csm_pkg::S_DONE:     state_next = csm_pkg::S_IDLE;
            default:             state_next = csm_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.status_code = csm_pkg::STS_OK;
        case (state_reg)
            csm_pkg::S_IDLE:
            begin
                cmd.load = start;
            end
            csm_pkg::S_DECODE:
            begin
                case (stat.op)
                    csm_pkg::OP_ADD:
                    begin
                        if (stat.row_ok && stat.col_ok)
                        begin
                            cmd.off_rd_lo = 1'b1;
                        end
                        else
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = csm_pkg::STS_OOB;
                        end
                    end
                    csm_pkg::OP_MUL:
                    begin
                        if (stat.row_ok)
                        begin
                            cmd.off_rd_lo = 1'b1;
                        end
                        else
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = csm_pkg::STS_OOB;
                        end
                    end
                    csm_pkg::OP_VEC:
                    begin
                        if (stat.col_ok)
                        begin
                            cmd.vec_wr = 1'b1;
                        end
                        else
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = csm_pkg::STS_OOB;
                        end
                    end
                    default:
                    begin
                        cmd.clr = 1'b1;
                    end
                endcase
            end
            csm_pkg::S_OFF_HI:
            begin
                cmd.cap_begin = 1'b1;
                cmd.off_rd_hi = 1'b1;
            end
            csm_pkg::S_OFF_END:
            begin
                cmd.cap_end = 1'b1;
            end
            csm_pkg::S_SRCH_CMP:
            begin
                cmd.pos_inc  = stat.col_lt;
                cmd.merge_wr = !stat.col_lt && stat.col_eq;
            end
            csm_pkg::S_INS_CHK:
            begin
                if (stat.full)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = csm_pkg::STS_FULL;
                end
                else
                begin
                    cmd.shift_init = 1'b1;
                end
            end
            csm_pkg::S_SHIFT_RD:
            begin
                cmd.shift_rd = stat.k_gt_pos;
            end
            csm_pkg::S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
            end
            csm_pkg::S_PLACE:
            begin
                cmd.place_wr = 1'b1;
            end
            csm_pkg::S_INC_WR:
            begin
                cmd.inc_wr = 1'b1;
            end
            csm_pkg::S_PR_RD:
            begin
                cmd.pr_ent_rd = stat.k_lt_end;
            end
            csm_pkg::S_PR_ENT:
            begin
                cmd.pr_vec_rd = 1'b1;
            end
            csm_pkg::S_PR_VEC:
            begin
                cmd.pr_mul = 1'b1;
            end
            csm_pkg::S_PR_ACC:
            begin
                cmd.pr_acc = 1'b1;
            end
            csm_pkg::S_DONE:
            begin
                cmd.respond = 1'b1;
            end
            default:
            begin
                cmd.respond = 1'b0;
            end
        endcase
    end

    assign busy = (state_reg != csm_pkg::S_IDLE);

endmodule

### design/csm_datapath.sv
`include "csr_sparse_matvec_top_macros.svh"

module csm_datapath #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLS    = 64,
    parameter int MAX_ENTRIES = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [csm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [csm_pkg::CFG_W-1:0]            cfg_data,
    input  logic [1:0]                           operation,
    input  logic [csm_pkg::ROW_W-1:0]            row,
    input  logic [csm_pkg::COL_W-1:0]            col,
    input  logic signed [csm_pkg::VAL_W-1:0]     value,
    input  csm_pkg::cmd_t                        cmd,
    output csm_pkg::stat_t                       stat,
    output logic                                 done,
    output logic [1:0]                           status,
    output logic signed [csm_pkg::VAL_W-1:0]     product_value,
    output logic [csm_pkg::CNT_OUT_W-1:0]        entry_count
);

    localparam int ROW_AW = $clog2(MAX_ROWS + 1);
    localparam int IW     = $clog2(MAX_ROWS + 2);
    localparam int EAW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int VAW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int EW     = csm_pkg::COL_W + csm_pkg::VAL_W;
    localparam int VW     = csm_pkg::VAL_W;

    function automatic logic signed [VW-1:0] sat32(input logic signed [63:0] v);
        logic signed [VW-1:0] r;
        if ((&v[63:VW-1]) || !(|v[63:VW-1]))
        begin
            r = v[VW-1:0];
        end
        else if (v[63])
        begin
            r = {1'b1, {(VW-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(VW-1){1'b1}}};
        end
        return r;
    endfunction

    csm_pkg::op_t            op_reg;
    logic [csm_pkg::ROW_W-1:0] row_reg;
    logic [csm_pkg::COL_W-1:0] col_reg;
    logic signed [VW-1:0]    val_reg;
    logic [csm_pkg::CFG_W-1:0] row_count_reg;
    logic [csm_pkg::CFG_W-1:0] col_count_reg;
    logic [CNT_W-1:0]        begin_reg;
    logic [CNT_W-1:0]        end_reg;
    logic [CNT_W-1:0]        pos_reg;
    logic [CNT_W-1:0]        k_reg;
    logic [IW-1:0]           i_reg;
    logic [CNT_W-1:0]        stored_reg;
    logic signed [63:0]      acc_reg;
    logic signed [63:0]      prod_reg;
    logic signed [VW-1:0]    ent_val_reg;
    logic [MAX_ROWS:0]       off_valid_reg;
    logic                    off_hit_reg;
    logic [MAX_COLS-1:0]     vec_valid_reg;
    logic                    vec_hit_reg;
    csm_pkg::status_t        status_reg;
    logic                    done_reg;
    logic [1:0]              status_out_reg;
    logic signed [VW-1:0]    product_reg;
    logic [csm_pkg::CNT_OUT_W-1:0] count_reg;

    logic [15:0]             row_wide;
    logic [15:0]             row_m1;
    logic [15:0]             col_wide;
    logic [15:0]             col_m1;
    logic [31:0]             stored_wide;

    logic [ROW_AW-1:0]       off_raddr;
    logic [ROW_AW-1:0]       off_waddr;
    logic                    off_we;
    logic [CNT_W-1:0]        off_wdata;
    logic [CNT_W-1:0]        off_q;
    logic [CNT_W-1:0]        off_rdata;

    logic [EAW-1:0]          ent_raddr;
    logic [EAW-1:0]          ent_waddr;
    logic                    ent_we;
    logic [EW-1:0]           ent_wdata;
    logic [EW-1:0]           ent_q;
    logic [csm_pkg::COL_W-1:0] ent_q_col;
    logic signed [VW-1:0]    ent_q_val;
    logic [CNT_W-1:0]        k_m1;
    logic signed [63:0]      merge_sum;

    logic [15:0]             ent_col_wide;
    logic [15:0]             ent_col_m1;
    logic [VAW-1:0]          vec_raddr;
    logic [VAW-1:0]          vec_waddr;
    logic [VW-1:0]           vec_q;
    logic signed [VW-1:0]    vec_x;
    logic                    ent_col_ok;

    assign row_wide     = 16'(row_reg);
    assign row_m1       = row_wide - 16'd1;
    assign col_wide     = 16'(col_reg);
    assign col_m1       = col_wide - 16'd1;
    assign stored_wide  = 32'(stored_reg);
    assign ent_q_col    = ent_q[EW-1:VW];
    assign ent_q_val    = ent_q[VW-1:0];
    assign k_m1         = k_reg - CNT_W'(1);
    assign ent_col_wide = 16'(ent_q_col);
    assign ent_col_m1   = ent_col_wide - 16'd1;
    assign ent_col_ok   = (ent_q_col != '0) && (ent_col_wide <= 16'(MAX_COLS));
    assign merge_sum    = 64'(ent_q_val) + 64'(val_reg);

    // Row offset store; a cleared row reads as zero.
    always_comb
    begin
        if (cmd.off_rd_lo)
        begin
            off_raddr = row_m1[ROW_AW-1:0];
        end
        else if (cmd.off_rd_hi)
        begin
            off_raddr = row_wide[ROW_AW-1:0];
        end
        else
        begin
            off_raddr = i_reg[ROW_AW-1:0];
        end
    end

    assign off_rdata = off_hit_reg ? off_q : '0;
    assign off_we    = cmd.inc_wr;
    assign off_waddr = i_reg[ROW_AW-1:0];
    assign off_wdata = off_rdata + CNT_W'(1);

    csm_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_ROWS + 1)
    ) u_off_ram (
        .clk   (clk),
        .we    (off_we),
        .waddr (off_waddr),
        .wdata (off_wdata),
        .raddr (off_raddr),
        .rdata (off_q)
    );

    // Entry store: column and value side by side.
    always_comb
    begin
        if (cmd.shift_rd)
        begin
            ent_raddr = k_m1[EAW-1:0];
        end
        else if (cmd.pr_ent_rd)
        begin
            ent_raddr = k_reg[EAW-1:0];
        end
        else
        begin
            ent_raddr = pos_reg[EAW-1:0];
        end
    end

    always_comb
    begin
        ent_we    = cmd.merge_wr || cmd.shift_wr || cmd.place_wr;
        ent_waddr = pos_reg[EAW-1:0];
        ent_wdata = {col_reg, val_reg};
        if (cmd.merge_wr)
        begin
            ent_wdata = {ent_q_col, sat32(merge_sum)};
        end
        else if (cmd.shift_wr)
        begin
            ent_waddr = k_reg[EAW-1:0];
            ent_wdata = ent_q;
        end
    end

    csm_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_q)
    );

    // Vector store; an element never written reads as zero.
    assign vec_raddr = ent_col_m1[VAW-1:0];
    assign vec_waddr = col_m1[VAW-1:0];
    assign vec_x     = vec_hit_reg ? vec_q : '0;

    csm_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_COLS)
    ) u_vec_ram (
        .clk   (clk),
        .we    (cmd.vec_wr),
        .waddr (vec_waddr),
        .wdata (val_reg),
        .raddr (vec_raddr),
        .rdata (vec_q)
    );

    always_comb
    begin
        stat.op         = op_reg;
        stat.row_ok     = (row_reg != '0) && (row_reg <= row_count_reg)
                          && (row_wide <= 16'(MAX_ROWS));
        stat.col_ok     = (col_reg != '0) && (col_reg <= col_count_reg)
                          && (col_wide <= 16'(MAX_COLS));
        stat.pos_lt_end = (pos_reg < end_reg);
        stat.col_lt     = (ent_q_col < col_reg);
        stat.col_eq     = (ent_q_col == col_reg);
        stat.full       = (stored_reg >= CNT_W'(MAX_ENTRIES));
        stat.k_gt_pos   = (k_reg > pos_reg);
        stat.i_le_max   = (i_reg <= IW'(MAX_ROWS));
        stat.k_lt_end   = (k_reg < end_reg);
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        off_hit_reg <= off_valid_reg[off_raddr];
        if (cmd.load)
        begin
            op_reg  <= csm_pkg::op_t'(operation);
            row_reg <= row;
            col_reg <= col;
            val_reg <= value;
            acc_reg <= '0;
        end
        if (cmd.cap_begin)
        begin
            begin_reg <= off_rdata;
        end
        if (cmd.cap_end)
        begin
            end_reg <= off_rdata;
            pos_reg <= begin_reg;
            k_reg   <= begin_reg;
        end
        if (cmd.pos_inc)
        begin
            pos_reg <= pos_reg + CNT_W'(1);
        end
        if (cmd.shift_init)
        begin
            k_reg <= stored_reg;
        end
        if (cmd.shift_wr)
        begin
            k_reg <= k_m1;
        end
        if (cmd.place_wr)
        begin
            i_reg <= row_wide[IW-1:0];
        end
        if (cmd.inc_wr)
        begin
            i_reg <= i_reg + IW'(1);
        end
        if (cmd.pr_vec_rd)
        begin
            ent_val_reg <= ent_q_val;
            vec_hit_reg <= vec_valid_reg[vec_raddr] && ent_col_ok;
        end
        if (cmd.pr_mul)
        begin
            prod_reg <= ent_val_reg * vec_x;
        end
        if (cmd.pr_acc)
        begin
            acc_reg <= acc_reg + ((prod_reg + 64'sd32768) >>> 16);
            k_reg   <= k_reg + CNT_W'(1);
        end
        if (cmd.respond)
        begin
            status_out_reg <= status_reg;
            product_reg    <= ((op_reg == csm_pkg::OP_MUL) && (status_reg == csm_pkg::STS_OK))
                              ? sat32(acc_reg) : '0;
            count_reg      <= stored_wide[csm_pkg::CNT_OUT_W-1:0];
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
            stored_reg    <= '0;
            off_valid_reg <= '0;
            vec_valid_reg <= '0;
            status_reg    <= csm_pkg::STS_OK;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.respond;
            if (cfg_valid)
            begin
                case (cfg_index)
                    csm_pkg::CFG_ROW_COUNT: row_count_reg <= cfg_data;
                    csm_pkg::CFG_COL_COUNT: col_count_reg <= cfg_data;
                    default:                row_count_reg <= row_count_reg;
                endcase
            end
            if (cmd.load)
            begin
                status_reg <= csm_pkg::STS_OK;
            end
            if (cmd.set_status)
            begin
                status_reg <= cmd.status_code;
            end
            if (cmd.clr)
            begin
                stored_reg    <= '0;
                off_valid_reg <= '0;
            end
            if (cmd.place_wr)
            begin
                stored_reg <= stored_reg + CNT_W'(1);
            end
            if (cmd.inc_wr)
            begin
                off_valid_reg[off_waddr] <= 1'b1;
            end
            if (cmd.vec_wr)
            begin
                vec_valid_reg[vec_waddr] <= 1'b1;
            end
        end
    end

    assign done          = done_reg;
    assign status        = status_out_reg;
    assign product_value = product_reg;
    assign entry_count   = count_reg;

    `CSM_ASSERT_NEXT(a_done_single, done_reg, !done_reg, "result strobe held two cycles")
    `CSM_ASSERT_ALWAYS(a_count_bound, stored_reg <= CNT_W'(MAX_ENTRIES), "entry count overflow")
    `CSM_ASSERT_IMPLY(a_full_status, cmd.respond && status_reg == csm_pkg::STS_FULL, stat.full, "full status with room left")
    `CSM_ASSERT_IMPLY(a_zero_product, done_reg && status_out_reg != csm_pkg::STS_OK, product_reg == '0, "product on failed item")

endmodule

### design/csr_sparse_matvec_top.sv
// Sparse matrix store in compressed-row form with a Q16.16 row product.
// Command channel: drive operation/row/col/value with start; a word is taken
// at a clock edge where start is high and busy is low. Operations: add
// triplet, write vector element, multiply one row, clear matrix.
// Result channel: done pulses for one cycle with status, product_value and
// entry_count; the receiver cannot stall, so take the word on that edge.
// Config channel: cfg_valid/cfg_ready (ready always high) with cfg_index and
// cfg_data; write only while busy is low and no result is pending.
// The walks over the entry and offset RAMs set the time from the accepting
// edge to the done cycle:
//   vector write, clear, rejected item: no walk.
//   row product: entry read, vector read, multiply, accumulate per entry.
//   triplet merge or store full: a search step per entry passed.
//   triplet insert: the search, then a shift per entry shifted and an
//   increment per row offset, from the row up to MAX_ROWS.
// One item at a time; the next is taken at the first edge where busy is low.
// Reset clears the entry count, row offsets and vector to zero through valid
// bits at once, so no clearing pass is needed.
module csr_sparse_matvec_top #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLS    = 64,
    parameter int MAX_ENTRIES = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           operation,
    input  logic [csm_pkg::ROW_W-1:0]            row,
    input  logic [csm_pkg::COL_W-1:0]            col,
    input  logic signed [csm_pkg::VAL_W-1:0]     value,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [csm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [csm_pkg::CFG_W-1:0]            cfg_data,
    output logic                                 done,
    output logic [1:0]                           status,
    output logic signed [csm_pkg::VAL_W-1:0]     product_value,
    output logic [csm_pkg::CNT_OUT_W-1:0]        entry_count
);

    csm_pkg::cmd_t  cmd;
    csm_pkg::stat_t stat;

    // Registers are always writable; a write lands at the edge where cfg_valid is high.
    assign cfg_ready = 1'b1;

    // Sequencer: steps through offset fetch, search, shift, offset update and product walk.
    csm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Storage, counters, multiplier and accumulator.
    csm_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .operation     (operation),
        .row           (row),
        .col           (col),
        .value         (value),
        .cmd           (cmd),
        .stat          (stat),
        .done          (done),
        .status        (status),
        .product_value (product_value),
        .entry_count   (entry_count)
    );

endmodule
